// ----- src/dltq_pkg.sv -----
// package: shared constants and codes for the delta-list timer queue
`default_nettype none
package dltq_pkg;

  localparam int DEF_MAX_TASKS  = 16;
  localparam int DEF_DELAY_BITS = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int RES_CNT_BITS   = $clog2(MAX_RESULTS + 1);
  localparam int ID_BITS        = 8;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_DISPATCH = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ----- src/dltq_mem.sv -----
// entry memory: one write port, one registered read port
`default_nettype none
module dltq_mem
  import dltq_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_TASKS,
  parameter int WIDTH = ID_BITS + 2 * DEF_DELAY_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/dltq_alu.sv -----
// shared subtractor with borrow, used for walk, adjust and tick
`default_nettype none
module dltq_alu
  import dltq_pkg::*;
#(
  parameter int W = DEF_DELAY_BITS
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              borrow
);

  logic [W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule
`default_nettype wire

// ----- src/delta_list_task_timer_queue.sv -----
// top level: delta-list timer queue with command sequencer
//
// Command port: a command beat (command, task_id, delay, period) is taken at a
// rising edge where start is high and busy is low. busy stays high while the
// sequencer works on the command.
// Result port: each result is shown for one cycle with strobe high; fired_id,
// fired, last and status are valid then. Every command gives one result with
// last set, except a dispatch with due tasks, which gives one result per due
// task (at most 16) and sets last on the final one. The receiver cannot stall.
// Structure: entries sit in a memory with one write port and a registered
// read port; one subtractor serves every delta update. Clear, unused codes
// and commands on an empty or full queue answer straight from idle. Tick
// lowers a nonzero head delta by one; delete head shifts later entries. Add
// walks to place P, shifts entries from P, inserts, adjusts any next delta.
// A dispatch costs a removal plus, for periodic tasks, an add per due task.
// Reset: rst (synchronous) empties the queue and idles the sequencer; memory
// contents are not cleared.
`default_nettype none
module delta_list_task_timer_queue
  import dltq_pkg::*;
#(
  parameter int MAX_TASKS  = DEF_MAX_TASKS,
  parameter int DELAY_BITS = DEF_DELAY_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [2:0]   command,
  input  wire logic [7:0]   task_id,
  input  wire logic [15:0]  delay,
  input  wire logic [15:0]  period,
  output logic              strobe,
  output logic      [7:0]   fired_id,
  output logic              fired,
  output logic              last,
  output logic      [1:0]   status
);

  localparam int IW       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW       = $clog2(MAX_TASKS + 1);
  localparam int EW       = ID_BITS + 2 * DELAY_BITS;
  localparam int EXT_BITS = (DELAY_BITS > 16) ? DELAY_BITS : 16;
  localparam logic [EXT_BITS-1:0] DMAX_EXT = EXT_BITS'({DELAY_BITS{1'b1}});

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_TK_RD  = 15'h0002,
    S_TK_WR  = 15'h0004,
    S_WK_RD  = 15'h0008,
    S_WK_CMP = 15'h0010,
    S_SH_RD  = 15'h0020,
    S_SH_WR  = 15'h0040,
    S_INS_WR = 15'h0080,
    S_ADJ_RD = 15'h0100,
    S_ADJ_WR = 15'h0200,
    S_RM_RD  = 15'h0400,
    S_RM_WR  = 15'h0800,
    S_DP_RD  = 15'h1000,
    S_DP_CHK = 15'h2000,
    S_IDLE2  = 15'h4000
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           pos;
  logic [CW-1:0]           idx;
  logic [DELAY_BITS-1:0]   rem;
  logic [ID_BITS-1:0]      nid;
  logic [DELAY_BITS-1:0]   nper;
  logic                    in_disp;
  logic [RES_CNT_BITS-1:0] n;
  logic                    pend_valid;
  logic [ID_BITS-1:0]      pend_id;

  logic [CW-1:0]           idx_m1;
  logic [CW-1:0]           pos_p1;
  logic [EXT_BITS-1:0]     delay_ext;
  logic [EXT_BITS-1:0]     period_ext;
  logic [DELAY_BITS-1:0]   delay_sat;
  logic [DELAY_BITS-1:0]   period_sat;

  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [EW-1:0]           mem_wdata;
  logic [IW-1:0]           mem_raddr;
  logic [EW-1:0]           mem_rdata;
  logic [ID_BITS-1:0]      rd_id;
  logic [DELAY_BITS-1:0]   rd_delta;
  logic [DELAY_BITS-1:0]   rd_per;

  logic [DELAY_BITS-1:0]   alu_a;
  logic [DELAY_BITS-1:0]   alu_b;
  logic [DELAY_BITS-1:0]   alu_diff;
  logic                    alu_borrow;

  assign busy     = (state != S_IDLE);
  assign idx_m1   = idx - CW'(1);
  assign pos_p1   = pos + CW'(1);
  assign rd_id    = mem_rdata[EW-1 -: ID_BITS];
  assign rd_delta = mem_rdata[2*DELAY_BITS-1 : DELAY_BITS];
  assign rd_per   = mem_rdata[DELAY_BITS-1:0];

  assign delay_ext  = EXT_BITS'(delay);
  assign period_ext = EXT_BITS'(period);
  assign delay_sat  = (delay_ext > DMAX_EXT) ? {DELAY_BITS{1'b1}} : delay_ext[DELAY_BITS-1:0];
  assign period_sat = (period_ext > DMAX_EXT) ? {DELAY_BITS{1'b1}} : period_ext[DELAY_BITS-1:0];

  dltq_mem #(
    .DEPTH (MAX_TASKS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dltq_alu #(
    .W (DELAY_BITS)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  always_comb begin
    alu_a = rem;
    alu_b = rd_delta;
    unique case (state)
      S_ADJ_WR: begin
        alu_a = rd_delta;
        alu_b = rem;
      end
      S_TK_WR: begin
        alu_a = rd_delta;
        alu_b = DELAY_BITS'(1);
      end
      default: begin
        alu_a = rem;
        alu_b = rd_delta;
      end
    endcase
  end

  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    unique case (state)
      S_WK_RD:  mem_raddr = pos[IW-1:0];
      S_SH_RD:  mem_raddr = idx_m1[IW-1:0];
      S_ADJ_RD: mem_raddr = pos_p1[IW-1:0];
      S_RM_RD:  mem_raddr = idx[IW-1:0];
      S_TK_WR: begin
        mem_we    = (rd_delta != '0);
        mem_waddr = '0;
        mem_wdata = {rd_id, alu_diff, rd_per};
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[IW-1:0];
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos[IW-1:0];
        mem_wdata = {nid, rem, nper};
      end
      S_ADJ_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_p1[IW-1:0];
        mem_wdata = {rd_id, alu_diff, rd_per};
      end
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1[IW-1:0];
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE, S_IDLE2: begin
          state <= S_IDLE;
          if (start && state == S_IDLE) begin
            fired_id <= '0;
            fired    <= 1'b0;
            last     <= 1'b1;
            status   <= STAT_OK;
            case (cmd_t'(command))
              CMD_TICK: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  status <= STAT_EMPTY;
                end else begin
                  state <= S_TK_RD;
                end
              end
              CMD_ADD: begin
                if (count == CW'(MAX_TASKS)) begin
                  strobe <= 1'b1;
                  status <= STAT_FULL;
                end else begin
                  nid     <= task_id;
                  rem     <= delay_sat;
                  nper    <= period_sat;
                  pos     <= '0;
                  in_disp <= 1'b0;
                  state   <= S_WK_RD;
                end
              end
              CMD_DISPATCH: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  status <= STAT_EMPTY;
                end else begin
                  in_disp    <= 1'b1;
                  n          <= '0;
                  pend_valid <= 1'b0;
                  state      <= S_DP_RD;
                end
              end
              CMD_DEL_HEAD: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  status <= STAT_EMPTY;
                end else begin
                  in_disp <= 1'b0;
                  idx     <= CW'(1);
                  state   <= S_RM_RD;
                end
              end
              CMD_CLEAR: begin
                count  <= '0;
                strobe <= 1'b1;
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end
        S_TK_RD: state <= S_TK_WR;
        S_TK_WR: begin
          strobe   <= 1'b1;
          fired_id <= '0;
          fired    <= 1'b0;
          last     <= 1'b1;
          status   <= STAT_OK;
          state    <= S_IDLE;
        end
        S_WK_RD: state <= S_WK_CMP;
        S_WK_CMP: begin
          if (pos < count && !alu_borrow) begin
            rem   <= alu_diff;
            pos   <= pos_p1;
            state <= S_WK_RD;
          end else begin
            idx   <= count;
            state <= (count == pos) ? S_INS_WR : S_SH_RD;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          idx   <= idx_m1;
          state <= (idx_m1 == pos) ? S_INS_WR : S_SH_RD;
        end
        S_INS_WR: begin
          count <= count + CW'(1);
          if (pos < count) begin
            state <= S_ADJ_RD;
          end else if (in_disp) begin
            state <= S_DP_RD;
          end else begin
            strobe   <= 1'b1;
            fired_id <= '0;
            fired    <= 1'b0;
            last     <= 1'b1;
            status   <= STAT_OK;
            state    <= S_IDLE;
          end
        end
        S_ADJ_RD: state <= S_ADJ_WR;
        S_ADJ_WR: begin
          if (in_disp) begin
            state <= S_DP_RD;
          end else begin
            strobe   <= 1'b1;
            fired_id <= '0;
            fired    <= 1'b0;
            last     <= 1'b1;
            status   <= STAT_OK;
            state    <= S_IDLE;
          end
        end
        S_RM_RD: begin
          if (idx < count) begin
            state <= S_RM_WR;
          end else begin
            count <= count - CW'(1);
            if (!in_disp) begin
              strobe   <= 1'b1;
              fired_id <= '0;
              fired    <= 1'b0;
              last     <= 1'b1;
              status   <= STAT_OK;
              state    <= S_IDLE;
            end else if (nper != '0) begin
              rem   <= nper;
              pos   <= '0;
              state <= S_WK_RD;
            end else begin
              state <= S_DP_RD;
            end
          end
        end
        S_RM_WR: begin
          idx   <= idx + CW'(1);
          state <= S_RM_RD;
        end
        S_DP_RD: state <= S_DP_CHK;
        S_DP_CHK: begin
          status <= STAT_OK;
          if (count != '0 && rd_delta == '0 && n != RES_CNT_BITS'(MAX_RESULTS)) begin
            // previous due task is now known not to be the final one
            if (pend_valid) begin
              strobe   <= 1'b1;
              fired_id <= pend_id;
              fired    <= 1'b1;
              last     <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_id    <= rd_id;
            nid        <= rd_id;
            nper       <= rd_per;
            n          <= n + RES_CNT_BITS'(1);
            idx        <= CW'(1);
            state      <= S_RM_RD;
          end else begin
            strobe   <= 1'b1;
            fired_id <= pend_valid ? pend_id : '0;
            fired    <= pend_valid;
            last     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/dltq_checker.sv -----
// port-level checker for the timer queue, bound to the top level
`default_nettype none
module dltq_checker
  import dltq_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [7:0] fired_id,
  input wire logic       fired,
  input wire logic       last,
  input wire logic [1:0] status
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("result or busy right after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || strobe)
    else $error("accepted command neither worked on nor answered");

  a_more_results_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result while block idle");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    strobe && status != STAT_OK |-> last && !fired)
    else $error("error status on a fired or non-final result");

  a_idle_id_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !fired |-> fired_id == 8'd0 && last)
    else $error("non-fired result with id or without last");

endmodule

bind delta_list_task_timer_queue dltq_checker u_dltq_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .strobe   (strobe),
  .fired_id (fired_id),
  .fired    (fired),
  .last     (last),
  .status   (status)
);
`default_nettype wire
